### hdl/pgm_pkg.sv
// Shared constants and types for the path glob matcher.
package pgm_pkg;

	localparam int PATTERN_MAX_DEF = 64;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_PATH   = 2'd2;
	localparam logic [1:0] CMD_TEST   = 2'd3;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic       fire;  // input transfer this cycle
		logic       path;  // transfer carries a path byte
		logic       keep;  // path byte that is not the last one
		logic       wr;    // pattern byte is stored this cycle
		logic [7:0] data;  // pattern or path byte
		logic       prop;  // new pattern byte lets a closure carry through
		logic       pass;  // new pattern byte is skipped by a closure carry
	} pgm_ctl_t;

	// per-cell terms for the closure network
	typedef struct packed {
		logic pre;   // active before closure
		logic gen;   // active star starts a carry
		logic prop;  // carry passes through
		logic pass;  // carry does not land here
	} pgm_link_t;

endpackage

### hdl/pgm_cell.sv
// One pattern position: stored byte, position flags and its share of the matcher state.
module pgm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  pgm_pkg::pgm_ctl_t   ctl,
	input  logic                sel,
	input  logic                valid,
	input  logic                seed,
	input  logic                act,
	input  logic                link_in,
	output logic                link_out,
	output logic                x,
	output logic                hit,
	output pgm_pkg::pgm_link_t  link
);

	logic [7:0] chr_q;
	logic       tail_q;   // star in the trailing star run of the pattern
	logic       multi_q;  // another star follows
	logic       gs_q;     // star run of two or more followed by a slash
	logic       pass_q;
	logic       prop_q;
	logic       topen_q;  // every later position lets a carry through
	logic       pre_q;
	logic       ins_q;    // skipping inside a directory component

	logic is_star;
	logic is_qmark;
	logic in_star;
	logic in_slash;
	logic live;
	logic grp;
	logic nself;
	logic nnext;
	logic nin;

	assign is_star  = (chr_q == pgm_pkg::CH_STAR);
	assign is_qmark = (chr_q == pgm_pkg::CH_QMARK);
	assign in_star  = (ctl.data == pgm_pkg::CH_STAR);
	assign in_slash = (ctl.data == pgm_pkg::CH_SLASH);
	assign live     = valid & ctl.path;
	assign grp      = act | ins_q;

	always_comb begin
		nself = 1'b0;
		nnext = 1'b0;
		nin   = 1'b0;
		if (live) begin
			if (is_star) begin
				if (gs_q) begin
					nself = grp & in_slash;
					nin   = grp & ~in_slash;
				end else if (multi_q) begin
					nself = act;
				end else begin
					nself = act & ~in_slash;
				end
			end else if (is_qmark) begin
				nnext = act & ~in_slash;
			end else begin
				nnext = act & (chr_q == ctl.data);
			end
		end
	end

	assign x        = nself | link_in;
	assign link_out = nnext;
	assign hit      = x & is_star & topen_q & valid;

	assign link.pre  = pre_q | seed;
	assign link.gen  = link.pre & is_star & valid;
	assign link.prop = prop_q & valid;
	assign link.pass = pass_q & valid;

	// pattern data
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			if (sel) begin
				chr_q   <= ctl.data;
				tail_q  <= in_star;
				multi_q <= 1'b0;
				gs_q    <= 1'b0;
				pass_q  <= ctl.pass;
				prop_q  <= ctl.prop;
				topen_q <= 1'b1;
			end else begin
				if (!in_star) tail_q <= 1'b0;
				if (in_star && tail_q) multi_q <= 1'b1;
				if (in_slash && tail_q && multi_q) gs_q <= 1'b1;
				if (valid) topen_q <= topen_q & ctl.prop;
			end
		end
	end

	// matcher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= 1'b0;
			ins_q <= 1'b0;
		end else if (ctl.fire) begin
			pre_q <= ctl.keep & x;
			ins_q <= ctl.keep & nin;
		end
	end

endmodule

### hdl/pgm_closure.sv
// Parallel-prefix network that forwards star closures across the cell row.
module pgm_closure #(
	parameter int N = pgm_pkg::PATTERN_MAX_DEF
) (
	input  pgm_pkg::pgm_link_t [N-1:0] links,
	input  logic                       pre_acc,
	output logic [N:0]                 act
);

	localparam int LV = $clog2(N);

	logic [N-1:0] g [LV+1];
	logic [N-1:0] p [LV+1];

	always_comb begin
		for (int i = 0; i < N; i++) begin
			g[0][i] = links[i].gen;
			p[0][i] = links[i].prop;
		end
		for (int l = 0; l < LV; l++) begin
			for (int i = 0; i < N; i++) begin
				if (i >= (1 << l)) begin
					g[l+1][i] = g[l][i] | (p[l][i] & g[l][i-(1<<l)]);
					p[l+1][i] = p[l][i] & p[l][i-(1<<l)];
				end else begin
					g[l+1][i] = g[l][i];
					p[l+1][i] = p[l][i];
				end
			end
		end
	end

	// g[LV][i] is the carry leaving position i
	always_comb begin
		act[0] = links[0].pre;
		for (int i = 1; i < N; i++) begin
			act[i] = links[i].pre | (g[LV][i-1] & ~links[i].pass);
		end
		act[N] = pre_acc | g[LV][N-1];
	end

endmodule

### hdl/path_glob_matcher.sv
// Top level of the path glob matcher: command decode, cell row, closure and result register.
//
// Glob matcher for streamed paths. Software sends a clear, then the pattern one byte per
// append transfer; path bytes follow one per transfer, and the byte flagged last (or an
// empty-path test) returns one result: matched, and pattern_overflow when more than
// PATTERN_MAX pattern bytes were sent (matched is then 0 until the next clear). A single
// '*' covers any run of non-slash bytes, a run of two or more stars covers anything and,
// when a '/' follows, zero or more whole directory components; '?' covers one non-slash
// byte. Appends and empty-path tests abandon a path in progress. The matcher is a row of
// PATTERN_MAX cells, one per pattern position, each holding its byte and its active and
// in-component bits, with an active bit passed to the right neighbor on a match. One
// item is accepted per cycle as long as the result register is free or being read, and
// the result is registered and appears in the cycle after its transfer. The cycle
// time is set by the star-closure prefix network ($clog2(PATTERN_MAX) levels) followed
// by the per-cell byte step and the OR across the cells that forms the result. There is
// no clearing pass after reset; the block accepts transfers right away.
module path_glob_matcher #(
	parameter int PATTERN_MAX = pgm_pkg::PATTERN_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] byte_value,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       matched,
	output logic       pattern_overflow
);

	localparam int CW = $clog2(PATTERN_MAX + 1);

	logic [CW-1:0] cnt_q;      // stored pattern length
	logic          ovf_q;      // pattern ran past the store
	logic [1:0]    trail_q;    // trailing stars in the pattern, saturates at two
	logic          start_q;    // state is the start position (before closure)
	logic          acc_q;      // accept bit when the store is full
	logic          out_valid_q;
	logic          matched_q;
	logic          povf_q;

	logic              fire;
	logic              full;
	logic              in_star;
	logic              in_slash;
	logic              emit;
	pgm_pkg::pgm_ctl_t ctl;

	logic [PATTERN_MAX:0]                chain;   // match handed to the right neighbor
	logic [PATTERN_MAX-1:0]              x_vec;   // active bits after this byte, unclosed
	logic [PATTERN_MAX-1:0]              hit_vec; // active star whose closure reaches the end
	logic [PATTERN_MAX:0]                act_vec; // closed active bits
	logic [PATTERN_MAX:0]                x_all;
	pgm_pkg::pgm_link_t [PATTERN_MAX-1:0] links;

	assign in_ready = ~out_valid_q | out_ready;
	assign fire     = in_valid & in_ready;
	assign full     = (cnt_q == CW'(PATTERN_MAX));
	assign in_star  = (byte_value == pgm_pkg::CH_STAR);
	assign in_slash = (byte_value == pgm_pkg::CH_SLASH);
	assign emit     = fire & (((cmd == pgm_pkg::CMD_PATH) & last) | (cmd == pgm_pkg::CMD_TEST));

	// a slash right after two or more stars is stepped over by the star run's closure
	assign ctl.fire = fire;
	assign ctl.path = (cmd == pgm_pkg::CMD_PATH);
	assign ctl.keep = (cmd == pgm_pkg::CMD_PATH) & ~last;
	assign ctl.wr   = fire & (cmd == pgm_pkg::CMD_APPEND) & ~full;
	assign ctl.data = byte_value;
	assign ctl.prop = in_star | (in_slash & trail_q[1]);
	assign ctl.pass = (in_star & (trail_q != 2'd0)) | (in_slash & trail_q[1]);

	// any transfer other than a path byte restarts from position zero
	assign chain[0] = ~ctl.path;

	genvar i;
	generate
		for (i = 0; i < PATTERN_MAX; i++) begin : g_cell
			pgm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.sel      (cnt_q == CW'(i)),
				.valid    (cnt_q > CW'(i)),
				.seed     (start_q && (i == 0)),
				.act      (act_vec[i]),
				.link_in  (chain[i]),
				.link_out (chain[i+1]),
				.x        (x_vec[i]),
				.hit      (hit_vec[i]),
				.link     (links[i])
			);
		end
	endgenerate

	pgm_closure #(
		.N (PATTERN_MAX)
	) u_closure (
		.links   (links),
		.pre_acc (acc_q),
		.act     (act_vec)
	);

	assign x_all = {chain[PATTERN_MAX], x_vec};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			trail_q <= 2'd0;
			start_q <= 1'b1;
			acc_q   <= 1'b0;
		end else if (fire) begin
			start_q <= ~ctl.keep;
			acc_q   <= ctl.keep & chain[PATTERN_MAX];
			if (cmd == pgm_pkg::CMD_CLEAR) begin
				cnt_q   <= '0;
				ovf_q   <= 1'b0;
				trail_q <= 2'd0;
			end else if (cmd == pgm_pkg::CMD_APPEND) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q   <= cnt_q + CW'(1);
					trail_q <= in_star ? {trail_q != 2'd0, trail_q == 2'd0} : 2'd0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			matched_q <= ~ovf_q & (x_all[cnt_q] | (|hit_vec));
			povf_q    <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = povf_q;

	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && pattern_overflow))
		else $error("match reported with pattern overflow");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("overflow flag set with room left in the store");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid)
		else $error("result transfer not presented");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd == pgm_pkg::CMD_CLEAR) |=> (cnt_q == '0 && !ovf_q))
		else $error("clear did not empty the pattern");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !ctl.keep) |=> (start_q && !acc_q))
		else $error("matcher not restarted");

endmodule
